// File: sv/expert_cache_lru_with_retain_assert.svh
// Assertion macros used by the expert cache datapath.
// Each expects a clock named clk and an active-low reset named arst_n in scope.
`ifndef EXPERT_CACHE_LRU_WITH_RETAIN_ASSERT_SVH
`define EXPERT_CACHE_LRU_WITH_RETAIN_ASSERT_SVH

// Condition holds at every clock edge outside reset.
`define ECL_ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// Consequence holds in the same cycle as the antecedent.
`define ECL_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequence holds in the cycle after the antecedent.
`define ECL_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: sv/ecl_pkg.sv
`default_nettype none

package ecl_pkg;

	localparam int CACHE_SLOTS = 32;
	localparam int MAX_EXPERTS = 128;

	// Fixed field widths
	localparam int ID_W       = 7;
	localparam int OCC_W      = 6;
	localparam int CAPREG_W   = 6;
	localparam int TOTREG_W   = 8;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 8;

	localparam int SLOT_W = (CACHE_SLOTS > 1) ? $clog2(CACHE_SLOTS) : 1;
	localparam int CNT_W  = $clog2(CACHE_SLOTS + 1);
	localparam int MAP_W  = (MAX_EXPERTS > 1) ? $clog2(MAX_EXPERTS) : 1;
	localparam int CAP_W  = (CNT_W > CAPREG_W) ? CNT_W : CAPREG_W;
	localparam int TOT_W  = ($clog2(MAX_EXPERTS + 1) > TOTREG_W) ?
		$clog2(MAX_EXPERTS + 1) : TOTREG_W;

	localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY     = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_EXPERT_TOTAL = 1'b1;

	typedef enum logic [1:0] {
		OP_REQUEST = 2'd0,
		OP_TOUCH   = 2'd1,
		OP_RETAIN  = 2'd2,
		OP_CLEAR   = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		UPD_NONE,
		UPD_RETAIN_SET,
		UPD_RETAIN_CLR,
		UPD_APPEND,
		UPD_REPLACE
	} upd_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOOKUP,
		ST_SCAN,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic load;
		logic lookup;
		logic scan_step;
		upd_t upd;
		logic emit;
	} cmd_t;

	typedef struct packed {
		op_t  op;
		logic bad;
		logic resident;
		logic need_evict;
		logic scan_match;
		logic scan_last;
		logic out_free;
	} status_t;

endpackage

`default_nettype wire

// File: sv/ecl_ctrl.sv
`default_nettype none

module ecl_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  ecl_pkg::status_t status,
	output ecl_pkg::cmd_t    cmd
);

	ecl_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ecl_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d       = state_q;
		cmd.load      = 1'b0;
		cmd.lookup    = 1'b0;
		cmd.scan_step = 1'b0;
		cmd.upd       = ecl_pkg::UPD_NONE;
		cmd.emit      = 1'b0;
		in_stall      = (state_q != ecl_pkg::ST_IDLE);

		unique case (state_q)
			ecl_pkg::ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ecl_pkg::ST_LOOKUP;
				end
			end
			ecl_pkg::ST_LOOKUP: begin
				cmd.lookup = 1'b1;
				state_d    = ecl_pkg::ST_EMIT;
				unique case (status.op)
					ecl_pkg::OP_CLEAR: begin
						cmd.upd = ecl_pkg::UPD_RETAIN_CLR;
					end
					ecl_pkg::OP_RETAIN: begin
						if (!status.bad) cmd.upd = ecl_pkg::UPD_RETAIN_SET;
					end
					ecl_pkg::OP_REQUEST: begin
						if (!status.bad && !status.resident) begin
							if (status.need_evict) begin
								state_d = ecl_pkg::ST_SCAN;
							end else begin
								cmd.upd = ecl_pkg::UPD_APPEND;
							end
						end
					end
					ecl_pkg::OP_TOUCH: begin
						if (!status.bad && status.resident) state_d = ecl_pkg::ST_SCAN;
					end
					default: state_d = ecl_pkg::ST_EMIT;
				endcase
			end
			ecl_pkg::ST_SCAN: begin
				// walk one slot a cycle, oldest first
				if (status.scan_match || status.scan_last) begin
					cmd.upd = ecl_pkg::UPD_REPLACE;
					state_d = ecl_pkg::ST_EMIT;
				end else begin
					cmd.scan_step = 1'b1;
				end
			end
			ecl_pkg::ST_EMIT: begin
				// hold until the output register is free
				if (status.out_free) begin
					cmd.emit = 1'b1;
					state_d  = ecl_pkg::ST_IDLE;
				end
			end
			default: state_d = ecl_pkg::ST_IDLE;
		endcase
	end

endmodule

`default_nettype wire

// File: sv/ecl_datapath.sv
`default_nettype none
`include "expert_cache_lru_with_retain_assert.svh"

module ecl_datapath (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [ecl_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [ecl_pkg::CFG_DATA_W-1:0]   cfg_wdata,
	input  logic [1:0]                       operation,
	input  logic [ecl_pkg::ID_W-1:0]         expert_id,
	input  ecl_pkg::cmd_t                    cmd,
	output ecl_pkg::status_t                 status,
	input  logic                             out_stall,
	output logic                             out_valid,
	output logic                             hit,
	output logic                             evict_valid,
	output logic [ecl_pkg::ID_W-1:0]         evicted_expert,
	output logic [ecl_pkg::OCC_W-1:0]        occupancy,
	output logic                             bad_id
);

	logic [ecl_pkg::CAPREG_W-1:0] capacity_q;
	logic [ecl_pkg::TOTREG_W-1:0] expert_total_q;

	ecl_pkg::op_t                op_q;
	logic [ecl_pkg::ID_W-1:0]    id_q;
	logic [ecl_pkg::SLOT_W-1:0]  idx_q;
	logic [ecl_pkg::CNT_W-1:0]   count_q;
	logic [ecl_pkg::ID_W-1:0]    lru_q [ecl_pkg::CACHE_SLOTS];
	logic [ecl_pkg::MAX_EXPERTS-1:0] resident_q;
	logic [ecl_pkg::MAX_EXPERTS-1:0] retain_q;

	logic                        res_hit_q, res_ev_q, res_bad_q;
	logic [ecl_pkg::ID_W-1:0]    res_evid_q;

	logic                        out_valid_q, out_hit_q, out_ev_q, out_bad_q;
	logic [ecl_pkg::ID_W-1:0]    out_evid_q;
	logic [ecl_pkg::OCC_W-1:0]   out_occ_q;

	logic [ecl_pkg::TOT_W-1:0]   eff_total;
	logic [ecl_pkg::CAP_W-1:0]   eff_cap;
	logic [ecl_pkg::MAP_W-1:0]   map_id;
	logic [ecl_pkg::ID_W-1:0]    entry;
	logic [ecl_pkg::ID_W-1:0]    removed;
	logic [ecl_pkg::SLOT_W-1:0]  pos;
	logic [ecl_pkg::SLOT_W-1:0]  last_slot;
	logic                        bad_now;
	logic                        scan_match;
	logic                        out_free;

	always_comb begin
		eff_total = (ecl_pkg::TOT_W'(expert_total_q) > ecl_pkg::TOT_W'(ecl_pkg::MAX_EXPERTS)) ?
			ecl_pkg::TOT_W'(ecl_pkg::MAX_EXPERTS) : ecl_pkg::TOT_W'(expert_total_q);
		if (capacity_q == '0) begin
			eff_cap = ecl_pkg::CAP_W'(1);
		end else if (ecl_pkg::CAP_W'(capacity_q) > ecl_pkg::CAP_W'(ecl_pkg::CACHE_SLOTS)) begin
			eff_cap = ecl_pkg::CAP_W'(ecl_pkg::CACHE_SLOTS);
		end else begin
			eff_cap = ecl_pkg::CAP_W'(capacity_q);
		end
	end

	assign bad_now    = (op_q != ecl_pkg::OP_CLEAR) &&
		(ecl_pkg::TOT_W'(id_q) >= eff_total);
	assign map_id     = ecl_pkg::MAP_W'(id_q);
	assign entry      = lru_q[idx_q];
	assign scan_match = (op_q == ecl_pkg::OP_TOUCH) ? (entry == id_q) :
		!retain_q[ecl_pkg::MAP_W'(entry)];
	// every resident retained: fall back to the oldest slot
	assign pos        = scan_match ? idx_q : '0;
	assign removed    = scan_match ? entry : lru_q[0];
	assign last_slot  = ecl_pkg::SLOT_W'(count_q - ecl_pkg::CNT_W'(1));
	assign out_free   = !out_valid_q || !out_stall;

	always_comb begin
		status.op         = op_q;
		status.bad        = bad_now;
		status.resident   = resident_q[map_id];
		status.need_evict = ecl_pkg::CAP_W'(count_q) >= eff_cap;
		status.scan_match = scan_match;
		status.scan_last  = (ecl_pkg::CNT_W'(idx_q) + ecl_pkg::CNT_W'(1)) >= count_q;
		status.out_free   = out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q     <= ecl_pkg::CAPREG_W'(ecl_pkg::CACHE_SLOTS);
			expert_total_q <= ecl_pkg::TOTREG_W'(ecl_pkg::MAX_EXPERTS);
		end else if (cfg_we) begin
			unique case (cfg_index)
				ecl_pkg::CFG_CAPACITY:     capacity_q     <= cfg_wdata[ecl_pkg::CAPREG_W-1:0];
				ecl_pkg::CFG_EXPERT_TOTAL: expert_total_q <= cfg_wdata[ecl_pkg::TOTREG_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			resident_q <= '0;
			retain_q   <= '0;
		end else begin
			unique case (cmd.upd)
				ecl_pkg::UPD_RETAIN_SET: retain_q[map_id] <= 1'b1;
				ecl_pkg::UPD_RETAIN_CLR: retain_q <= '0;
				ecl_pkg::UPD_APPEND: begin
					resident_q[map_id] <= 1'b1;
					count_q            <= count_q + ecl_pkg::CNT_W'(1);
				end
				ecl_pkg::UPD_REPLACE: begin
					if (op_q == ecl_pkg::OP_REQUEST) resident_q[ecl_pkg::MAP_W'(removed)] <= 1'b0;
					resident_q[map_id] <= 1'b1;
				end
				default: ;
			endcase
		end
	end

	// Slot contents beyond the count are never read; no reset needed.
	always_ff @(posedge clk) begin
		if (cmd.upd == ecl_pkg::UPD_APPEND) begin
			lru_q[ecl_pkg::SLOT_W'(count_q)] <= id_q;
		end else if (cmd.upd == ecl_pkg::UPD_REPLACE) begin
			// close the gap, then place the expert as newest
			for (int i = 0; i < ecl_pkg::CACHE_SLOTS - 1; i++) begin
				if (ecl_pkg::CNT_W'(i) >= ecl_pkg::CNT_W'(pos) &&
					ecl_pkg::CNT_W'(i + 1) < count_q) begin
					lru_q[i] <= lru_q[i + 1];
				end
			end
			lru_q[last_slot] <= id_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_q       <= ecl_pkg::OP_REQUEST;
			id_q       <= '0;
			idx_q      <= '0;
			res_hit_q  <= 1'b0;
			res_ev_q   <= 1'b0;
			res_evid_q <= '0;
			res_bad_q  <= 1'b0;
		end else begin
			if (cmd.load) begin
				op_q       <= ecl_pkg::op_t'(operation);
				id_q       <= expert_id;
				idx_q      <= '0;
				res_hit_q  <= 1'b0;
				res_ev_q   <= 1'b0;
				res_evid_q <= '0;
				res_bad_q  <= 1'b0;
			end
			if (cmd.lookup) begin
				res_bad_q <= bad_now;
				res_hit_q <= !bad_now && resident_q[map_id] &&
					(op_q == ecl_pkg::OP_REQUEST || op_q == ecl_pkg::OP_TOUCH);
			end
			if (cmd.scan_step) idx_q <= idx_q + ecl_pkg::SLOT_W'(1);
			if (cmd.upd == ecl_pkg::UPD_REPLACE && op_q == ecl_pkg::OP_REQUEST) begin
				res_ev_q   <= 1'b1;
				res_evid_q <= removed;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_hit_q  <= res_hit_q;
			out_ev_q   <= res_ev_q;
			out_evid_q <= res_evid_q;
			out_occ_q  <= ecl_pkg::OCC_W'(count_q);
			out_bad_q  <= res_bad_q;
		end
	end

	assign out_valid      = out_valid_q;
	assign hit            = out_hit_q;
	assign evict_valid    = out_ev_q;
	assign evicted_expert = out_evid_q;
	assign occupancy      = out_occ_q;
	assign bad_id         = out_bad_q;

	`ECL_ASSERT_ALWAYS(a_count_max, count_q <= ecl_pkg::CNT_W'(ecl_pkg::CACHE_SLOTS), "count above slots")
	`ECL_ASSERT_NEXT(a_replace_count, cmd.upd == ecl_pkg::UPD_REPLACE, $stable(count_q), "replace moved count")
	`ECL_ASSERT_NEXT(a_append_count, cmd.upd == ecl_pkg::UPD_APPEND, count_q == $past(count_q) + ecl_pkg::CNT_W'(1), "append did not grow")
	`ECL_ASSERT_SAME(a_emit_free, cmd.emit, out_free, "result overwrote pending output")

endmodule

`default_nettype wire

// File: sv/expert_cache_lru_with_retain.sv
// Expert cache residency manager with LRU order and retain marks. One request
// in, one result out. A request is taken only while the block is idle and then
// occupies it through load, lookup and emit when no LRU walk is needed (hit,
// retain set, retain clear, invalid id, a touch of a non-resident expert, or a
// miss with free slots), and through a scan between lookup and emit when it
// walks the LRU order (a touch of a resident expert, or a miss on a full cache),
// visiting 1 to 32 slots: the walk examines one slot per cycle, oldest first.
// The result sits in an output register, so the next request is taken while it
// waits; a new result is only written once the previous one has gone.
`default_nettype none

module expert_cache_lru_with_retain (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [ecl_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [ecl_pkg::CFG_DATA_W-1:0] cfg_wdata,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [1:0]                     operation,
	input  logic [ecl_pkg::ID_W-1:0]       expert_id,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic                           hit,
	output logic                           evict_valid,
	output logic [ecl_pkg::ID_W-1:0]       evicted_expert,
	output logic [ecl_pkg::OCC_W-1:0]      occupancy,
	output logic                           bad_id
);

	ecl_pkg::cmd_t    cmd;
	ecl_pkg::status_t status;

	ecl_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.status   (status),
		.cmd      (cmd)
	);

	ecl_datapath u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_wdata      (cfg_wdata),
		.operation      (operation),
		.expert_id      (expert_id),
		.cmd            (cmd),
		.status         (status),
		.out_stall      (out_stall),
		.out_valid      (out_valid),
		.hit            (hit),
		.evict_valid    (evict_valid),
		.evicted_expert (evicted_expert),
		.occupancy      (occupancy),
		.bad_id         (bad_id)
	);

endmodule

`default_nettype wire

// File: tb/sv/expert_cache_lru_with_retain_test.sv
`default_nettype none

module expert_cache_lru_with_retain_test;
	import ecl_pkg::*;

	localparam int HOLD_CYCLES = 150;
	localparam int SETTLE_CYCLES = 40;
	localparam int RANDOM_PHASES = 14;
	localparam int PHASE_ITEMS = 110;

	typedef struct packed {
		logic              hit;
		logic              evict;
		logic [ID_W-1:0]   evicted;
		logic [OCC_W-1:0]  occ;
		logic              bad;
	} cache_result_t;

	// Residency model: LRU order oldest first, plus resident and retain maps.
	class expert_cache_board;
		logic [ID_W-1:0]     lru_ids [CACHE_SLOTS];
		int unsigned         resident_cnt;
		bit                  resident [MAX_EXPERTS];
		bit                  retained [MAX_EXPERTS];
		logic [CAPREG_W-1:0] capacity_reg;
		logic [TOTREG_W-1:0] total_reg;
		cache_result_t       awaited[$];
		int unsigned         errors, requests, hits, evictions, bad_ids;

		function new();
			capacity_reg = CAPREG_W'(CACHE_SLOTS);
			total_reg = TOTREG_W'(MAX_EXPERTS);
			resident_cnt = 0;
			foreach (resident[i]) begin
				resident[i] = 1'b0;
				retained[i] = 1'b0;
			end
			foreach (lru_ids[i])
				lru_ids[i] = '0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx,
				logic [CFG_DATA_W-1:0] v);
			if (idx == CFG_CAPACITY)
				capacity_reg = v[CAPREG_W-1:0];
			else
				total_reg = v[TOTREG_W-1:0];
		endfunction

		function void note_request(op_t op, logic [ID_W-1:0] id);
			cache_result_t r;
			int unsigned eff_cap, eff_tot, pos;
			eff_cap = (capacity_reg == 0) ? 1 :
				(capacity_reg > CACHE_SLOTS) ? CACHE_SLOTS : capacity_reg;
			eff_tot = (total_reg > MAX_EXPERTS) ? MAX_EXPERTS : total_reg;
			r = '0;
			r.bad = (op != OP_CLEAR) && (id >= eff_tot);
			requests++;
			if (op == OP_CLEAR) begin
				foreach (retained[i])
					retained[i] = 1'b0;
			end else if (!r.bad) begin
				case (op)
					OP_REQUEST: begin
						if (resident[id]) begin
							r.hit = 1'b1;
						end else begin
							if (resident_cnt >= eff_cap && resident_cnt > 0) begin
								// oldest without a retain mark, else the oldest
								pos = 0;
								for (int i = 0; i < resident_cnt; i++)
									if (!retained[lru_ids[i]]) begin
										pos = i;
										break;
									end
								r.evict = 1'b1;
								r.evicted = lru_ids[pos];
								resident[lru_ids[pos]] = 1'b0;
								for (int i = pos; i + 1 < resident_cnt; i++)
									lru_ids[i] = lru_ids[i+1];
								resident_cnt--;
							end
							lru_ids[resident_cnt] = id;
							resident_cnt++;
							resident[id] = 1'b1;
						end
					end
					OP_TOUCH: begin
						if (resident[id]) begin
							r.hit = 1'b1;
							pos = 0;
							while (lru_ids[pos] != id)
								pos++;
							for (int i = pos; i + 1 < resident_cnt; i++)
								lru_ids[i] = lru_ids[i+1];
							lru_ids[resident_cnt-1] = id;
						end
					end
					default: retained[id] = 1'b1;
				endcase
			end
			r.occ = OCC_W'(resident_cnt);
			hits += r.hit;
			evictions += r.evict;
			bad_ids += r.bad;
			awaited.insert(awaited.size(), r);
		endfunction

		function void check_result(cache_result_t got);
			cache_result_t want;
			if (awaited.size() == 0) begin
				$error({"result with nothing outstanding: ",
					"hit %0d evict %0d id %0d occ %0d bad %0d"},
					got.hit, got.evict, got.evicted, got.occ, got.bad);
				errors++;
				return;
			end
			want = awaited[0];
			awaited.delete(0);
			if (got.hit !== want.hit) begin
				$error("hit: expected %0d, got %0d", want.hit, got.hit);
				errors++;
			end
			if (got.evict !== want.evict) begin
				$error("evict_valid: expected %0d, got %0d", want.evict, got.evict);
				errors++;
			end
			if (got.evicted !== want.evicted) begin
				$error("evicted_expert: expected %0d, got %0d", want.evicted, got.evicted);
				errors++;
			end
			if (got.occ !== want.occ) begin
				$error("occupancy: expected %0d, got %0d", want.occ, got.occ);
				errors++;
			end
			if (got.bad !== want.bad) begin
				$error("bad_id: expected %0d, got %0d", want.bad, got.bad);
				errors++;
			end
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;
	logic                  in_valid;
	logic                  in_stall;
	logic [1:0]            operation;
	logic [ID_W-1:0]       expert_id;
	logic                  out_valid;
	logic                  out_stall;
	logic                  hit;
	logic                  evict_valid;
	logic [ID_W-1:0]       evicted_expert;
	logic [OCC_W-1:0]      occupancy;
	logic                  bad_id;

	expert_cache_board sb = new();
	bit          hold_off_req;
	int unsigned long_holds;
	int unsigned config_writes;

	expert_cache_lru_with_retain dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_wdata      (cfg_wdata),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.operation      (operation),
		.expert_id      (expert_id),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.hit            (hit),
		.evict_valid    (evict_valid),
		.evicted_expert (evicted_expert),
		.occupancy      (occupancy),
		.bad_id         (bad_id)
	);

	initial clk = 1'b0;
	always #1 clk = ~clk;

	initial begin
		#1_000_000;
		$display("FAIL expert_cache_lru_with_retain");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n && in_valid && !in_stall)
			sb.note_request(op_t'(operation), expert_id);
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_result({hit, evict_valid, evicted_expert, occupancy, bad_id});
	end

	// Receiver: stretches of random stall density, with a long hold-off on demand.
	initial begin
		int unsigned span_left, pct, hold_left;
		span_left = 0;
		pct = 0;
		hold_left = 0;
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				out_stall <= 1'b1;
				hold_left--;
			end else begin
				if (span_left == 0) begin
					span_left = $urandom_range(8, 64);
					case ($urandom_range(3))
						0: pct = 0;
						1: pct = 25;
						2: pct = 60;
						default: pct = 90;
					endcase
					if (hold_off_req) begin
						hold_off_req = 1'b0;
						hold_left = HOLD_CYCLES;
						long_holds++;
					end
				end
				out_stall <= ($urandom_range(99) < pct);
				span_left--;
			end
		end
	end

	task automatic send_req(input op_t op, input logic [ID_W-1:0] id);
		operation <= op;
		expert_id <= id;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic pause(input int unsigned n);
		in_valid <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	// Only called with the block idle and nothing outstanding.
	task automatic write_regs(input logic [CFG_DATA_W-1:0] cap_v,
			input logic [CFG_DATA_W-1:0] tot_v);
		cfg_we <= 1'b1;
		cfg_index <= CFG_CAPACITY;
		cfg_wdata <= cap_v;
		sb.write_reg(CFG_CAPACITY, cap_v);
		@(posedge clk);
		cfg_index <= CFG_EXPERT_TOTAL;
		cfg_wdata <= tot_v;
		sb.write_reg(CFG_EXPERT_TOTAL, tot_v);
		@(posedge clk);
		cfg_we <= 1'b0;
		config_writes++;
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		while (sb.awaited.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin
		logic [CFG_DATA_W-1:0] cap_v, tot_v;
		logic [ID_W-1:0]       pool[];
		int unsigned           eff_cap, lim, psize, mode, burst, r;
		op_t                   op;

		hold_off_req = 1'b0;
		long_holds = 0;
		config_writes = 0;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= CFG_CAPACITY;
		cfg_wdata <= '0;
		in_valid <= 1'b0;
		operation <= OP_REQUEST;
		expert_id <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Two slots: hits, plain eviction, retain skipping, all retained, clear.
		write_regs(8'd2, 8'd128);
		send_req(OP_REQUEST, 7'd0);
		send_req(OP_REQUEST, 7'd127);
		send_req(OP_REQUEST, 7'd0);
		send_req(OP_REQUEST, 7'd64);
		send_req(OP_TOUCH, 7'd127);
		send_req(OP_RETAIN, 7'd64);
		send_req(OP_REQUEST, 7'd10);
		send_req(OP_RETAIN, 7'd10);
		send_req(OP_REQUEST, 7'd20);
		send_req(OP_RETAIN, 7'd99);
		send_req(OP_CLEAR, 7'd85);
		send_req(OP_REQUEST, 7'd99);
		send_req(OP_TOUCH, 7'd33);
		send_req(OP_TOUCH, 7'd20);
		settle();

		// Zero capacity acts as one; zero total makes every id invalid.
		write_regs(8'hC0, 8'd0);
		send_req(OP_REQUEST, 7'd5);
		send_req(OP_TOUCH, 7'd127);
		send_req(OP_RETAIN, 7'd0);
		send_req(OP_CLEAR, 7'd127);
		settle();

		// Oversized registers saturate.
		write_regs(8'hFF, 8'hFF);
		send_req(OP_REQUEST, 7'd127);
		send_req(OP_REQUEST, 7'd1);
		send_req(OP_REQUEST, 7'd42);
		settle();

		// Capacity below occupancy, residents above a lowered total.
		write_regs(8'd1, 8'd3);
		send_req(OP_REQUEST, 7'd2);
		send_req(OP_TOUCH, 7'd99);
		send_req(OP_REQUEST, 7'd3);
		send_req(OP_REQUEST, 7'd0);
		send_req(OP_REQUEST, 7'd1);
		settle();

		for (int p = 0; p < RANDOM_PHASES; p++) begin
			case (p)
				0: begin cap_v = 8'd1; tot_v = 8'($urandom_range(2, 6)); end
				1: begin cap_v = 8'd32; tot_v = 8'd128; end
				2: begin cap_v = {2'($urandom), 6'd0}; tot_v = 8'($urandom_range(1, 3)); end
				3: begin cap_v = 8'hFF; tot_v = 8'hFF; end
				4: begin cap_v = 8'd32; tot_v = 8'd40; end
				5: begin
					cap_v = 8'($urandom_range(33, 63));
					tot_v = 8'($urandom_range(129, 255));
				end
				6: begin cap_v = 8'd4; tot_v = 8'd1; end
				default: begin
					cap_v = {2'($urandom), 6'($urandom_range(2, 16))};
					tot_v = 8'($urandom_range(cap_v[5:0], 3 * cap_v[5:0] + 8));
				end
			endcase
			eff_cap = (cap_v[5:0] == 0) ? 1 :
				(cap_v[5:0] > CACHE_SLOTS) ? CACHE_SLOTS : cap_v[5:0];
			lim = (tot_v > MAX_EXPERTS) ? MAX_EXPERTS : tot_v;
			psize = eff_cap + $urandom_range(1, eff_cap + 4);
			if (psize > lim)
				psize = (lim == 0) ? 1 : lim;
			// working set of ids just above capacity keeps both hits and evictions common
			pool = new[psize];
			foreach (pool[i])
				pool[i] = (lim == 0) ? 7'd0 : 7'($urandom_range(0, lim - 1));
			write_regs(cap_v, tot_v);
			if (p == 3 || p == 9)
				hold_off_req = 1'b1;
			mode = $urandom_range(2);
			burst = 0;
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				r = $urandom_range(99);
				op = (r < 55) ? OP_REQUEST : (r < 75) ? OP_TOUCH :
					(r < 94) ? OP_RETAIN : OP_CLEAR;
				if ($urandom_range(9) == 0)
					send_req(op, 7'($urandom));
				else
					send_req(op, pool[$urandom_range(0, psize - 1)]);
				if (mode == 1) begin
					if (burst == 0) begin
						pause($urandom_range(1, 8));
						burst = $urandom_range(1, 16);
					end else begin
						burst--;
					end
				end else if (mode == 2) begin
					pause($urandom_range(1, 3));
				end
			end
			settle();
		end

		$display("Covered %0d requests over %0d register settings:",
			sb.requests, config_writes);
		$display("  %0d hits, %0d evictions, %0d invalid ids.",
			sb.hits, sb.evictions, sb.bad_ids);
		$display("Receiver held off %0d times for %0d cycles with the sender still offering.",
			long_holds, HOLD_CYCLES);
		if (sb.errors == 0)
			$display("PASS expert_cache_lru_with_retain");
		else
			$display("FAIL expert_cache_lru_with_retain");
		$finish;
	end

endmodule

`default_nettype wire
